@@ rtl/core/tnfg_pkg.sv @@
// Shared constants, tables and types for the terrain normal pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tnfg_pkg;

    // Field widths.
    localparam int LAT_W     = 30;
    localparam int LON_W     = 31;
    localparam int ELEV_W    = 24;
    localparam int MASK_W    = 5;
    localparam int POS_W     = 32;
    localparam int NRM_W     = 32;
    localparam int S_TDATA_W = 256;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ELEV_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NGEN_EN = 1'b1;

    // Angles in degrees, LSB 2^-22.
    localparam logic [30:0] DEG_FULL        = 31'd1509949440;
    localparam logic [30:0] DEG_THREE_QUART = 31'd1132462080;
    localparam logic [30:0] DEG_HALF        = 31'd754974720;
    localparam logic [30:0] DEG_QUARTER     = 31'd377487360;
    localparam logic [27:0] DEG_EIGHTH      = 28'd188743680;
    // pi/180 in Q38
    localparam logic [32:0] RAD_PER_DEG_Q38 = 33'd4797524517;
    localparam logic [30:0] Q30_ONE         = 31'd1073741824;

    // Horner series divisors and their Q32 reciprocals.
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [COS_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
        32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
        32'(64'd4294967296 / 64'd6)};
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'(64'd4294967296 / 64'd132), 32'(64'd4294967296 / 64'd90),
        32'(64'd4294967296 / 64'd56),  32'(64'd4294967296 / 64'd30),
        32'(64'd4294967296 / 64'd12),  32'(64'd4294967296 / 64'd2)};

    // Pipeline depths.
    localparam int HSTEP_LAT   = 3;
    localparam int SC_PRE      = 4;
    localparam int SC_LAT      = SC_PRE + HSTEP_LAT * COS_STEPS + 1;
    localparam int CROSS_LAT   = 6;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int SIDE_DEPTH  = SC_LAT + CROSS_LAT + SQRT_STEPS + DIV_STEPS;

    typedef struct packed {
        logic                    ok;
        logic                    flip;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } side_t;

    typedef struct packed {
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
    } cvec_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic len_zero;
    } csign_t;

endpackage

`default_nettype wire

@@ rtl/core/terrain_normal_from_gradients.sv @@
// Top level: terrain vertex normal from neighbour elevation gradients.
`timescale 1ns / 1ps
`default_nettype none

// Takes one vertex word per cycle while the pipeline is not stalled and returns
// one normal word per vertex, in order. The pipeline is a single stall
// domain: it advances whenever the output register is empty or being taken,
// so s_tready follows m_tready while a result waits. The depth is set by the
// sine/cosine Horner chains (23 stages), the cross product (6), the 32-stage
// square root, the 31-stage divider for normalization and the outward test.
// The normal is zero with m_tuser low when either enable is clear, a sample
// is invalid, the north/south or east/west pair is flat, or the length is
// zero. Configuration writes take effect at once and belong between bursts.
module terrain_normal_from_gradients (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tnfg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [0:0]                            cfg_wdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // latitude_deg, longitude_deg, elev_north, elev_south, elev_east,
    // elev_west, pos_x, pos_y, pos_z, zero pad
    input  wire logic [tnfg_pkg::S_TDATA_W-1:0]        s_tdata,
    // sample_valid_mask
    input  wire logic [tnfg_pkg::MASK_W-1:0]           s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // normal_x, normal_y, normal_z
    output logic [tnfg_pkg::M_TDATA_W-1:0]             m_tdata,
    // normal_updated
    output logic [0:0]                                 m_tuser
);
    import tnfg_pkg::*;

    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // configuration
    logic elev_en_reg;
    logic ngen_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elev_en_reg <= 1'b0;
            ngen_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ELEV_EN: elev_en_reg <= cfg_wdata[0];
                CFG_NGEN_EN: ngen_en_reg <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // input unpacking
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
    logic signed [ELEV_W:0]   dn;
    logic signed [ELEV_W:0]   de;
    side_t                    side_in;

    always_comb begin
        lat          = s_tdata[29:0];
        lon          = s_tdata[60:30];
        dn           = {s_tdata[84], s_tdata[84:61]} - {s_tdata[108], s_tdata[108:85]};
        de           = {s_tdata[132], s_tdata[132:109]} - {s_tdata[156], s_tdata[156:133]};
        side_in.ok   = elev_en_reg && ngen_en_reg && (s_tuser == {MASK_W{1'b1}})
                       && (dn != '0) && (de != '0);
        side_in.flip = dn[ELEV_W] ^ de[ELEV_W];
        side_in.px   = s_tdata[188:157];
        side_in.py   = s_tdata[220:189];
        side_in.pz   = s_tdata[252:221];
    end

    side_t side_pipe_reg [SIDE_DEPTH];
    logic  vld_pipe_reg  [SIDE_DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_pipe_reg[0] <= side_in;
            for (int i = 1; i < SIDE_DEPTH; i++) side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_DEPTH; i++) vld_pipe_reg[i] <= 1'b0;
        end else if (en) begin
            vld_pipe_reg[0] <= s_tvalid;
            for (int i = 1; i < SIDE_DEPTH; i++) vld_pipe_reg[i] <= vld_pipe_reg[i-1];
        end
    end

    // trig
    logic signed [31:0] sl;
    logic signed [31:0] cl;
    logic signed [31:0] sn;
    logic signed [31:0] cn;

    tnfg_sincos u_lat_sc (
        .aclk  (aclk),
        .en    (en),
        .ang_i ({lat[LAT_W-1], lat}),
        .sin_o (sl),
        .cos_o (cl)
    );

    tnfg_sincos u_lon_sc (
        .aclk  (aclk),
        .en    (en),
        .ang_i (lon),
        .sin_o (sn),
        .cos_o (cn)
    );

    // cross product
    logic signed [63:0] cc_reg;
    logic signed [63:0] psc_reg;
    logic signed [63:0] pss_reg;
    logic signed [31:0] sn1_reg;
    logic signed [31:0] cn1_reg;
    logic signed [31:0] cl1_reg;
    logic [30:0]        cl2;
    logic signed [63:0] a1_reg;
    logic signed [63:0] a2_reg;
    logic signed [63:0] psc2_reg;
    logic signed [63:0] pss2_reg;
    logic signed [31:0] cl2_reg;
    logic signed [63:0] cx60_reg;
    logic signed [63:0] cz60_reg;
    logic signed [31:0] cl3_reg;
    logic [63:0]        mag_x;
    logic [63:0]        mag_z;
    logic [63:0]        rsum_x;
    logic [63:0]        rsum_z;
    logic [32:0]        rx;
    logic [32:0]        rz;
    cvec_t              c4_reg;
    logic signed [65:0] sqx_full;
    logic signed [65:0] sqy_full;
    logic signed [65:0] sqz_full;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic [63:0]        sqz_reg;
    cvec_t              c5_reg;
    logic [63:0]        ssum_reg;
    cvec_t              c6_reg;

    assign cl2 = cc_reg[60:30];

    always_comb begin
        mag_x    = cx60_reg[63] ? 64'(-cx60_reg) : cx60_reg;
        mag_z    = cz60_reg[63] ? 64'(-cz60_reg) : cz60_reg;
        rsum_x   = mag_x + (64'd1 << 29);
        rsum_z   = mag_z + (64'd1 << 29);
        rx       = rsum_x[62:30];
        rz       = rsum_z[62:30];
        sqx_full = 66'(c4_reg.cx) * 66'(c4_reg.cx);
        sqy_full = 66'(c4_reg.cy) * 66'(c4_reg.cy);
        sqz_full = 66'(c4_reg.cz) * 66'(c4_reg.cz);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg    <= 64'(cl) * 64'(cl);
            psc_reg   <= 64'(sl) * 64'(cn);
            pss_reg   <= 64'(sl) * 64'(sn);
            sn1_reg   <= sn;
            cn1_reg   <= cn;
            cl1_reg   <= cl;

            a1_reg    <= 64'(sn1_reg) * $signed(64'(cl2));
            a2_reg    <= 64'(cn1_reg) * $signed(64'(cl2));
            psc2_reg  <= psc_reg;
            pss2_reg  <= pss_reg;
            cl2_reg   <= cl1_reg;

            cx60_reg  <= a1_reg - psc2_reg;
            cz60_reg  <= -a2_reg - pss2_reg;
            cl3_reg   <= cl2_reg;

            // Q60 to Q30, half away from zero
            c4_reg.cx <= cx60_reg[63] ? $signed(33'(-rx)) : $signed(rx);
            c4_reg.cz <= cz60_reg[63] ? $signed(33'(-rz)) : $signed(rz);
            c4_reg.cy <= 33'(cl3_reg);

            sqx_reg   <= sqx_full[63:0];
            sqy_reg   <= sqy_full[63:0];
            sqz_reg   <= sqz_full[63:0];
            c5_reg    <= c4_reg;

            ssum_reg  <= sqx_reg + sqy_reg + sqz_reg;
            c6_reg    <= c5_reg;
        end
    end

    // length
    logic [31:0] len;
    cvec_t       c_pipe_reg [SQRT_STEPS];

    tnfg_isqrt u_isqrt (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (ssum_reg),
        .root_o (len)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            c_pipe_reg[0] <= c6_reg;
            for (int i = 1; i < SQRT_STEPS; i++) c_pipe_reg[i] <= c_pipe_reg[i-1];
        end
    end

    // normalization
    cvec_t       cq;
    logic [32:0] mx;
    logic [32:0] my;
    logic [32:0] mz;
    logic [62:0] numx;
    logic [62:0] numy;
    logic [62:0] numz;
    logic [30:0] qx;
    logic [30:0] qy;
    logic [30:0] qz;
    csign_t      sgn_in;
    csign_t      sgn_pipe_reg [DIV_STEPS];

    always_comb begin
        cq              = c_pipe_reg[SQRT_STEPS-1];
        mx              = cq.cx[32] ? 33'(-cq.cx) : cq.cx;
        my              = cq.cy[32] ? 33'(-cq.cy) : cq.cy;
        mz              = cq.cz[32] ? 33'(-cq.cz) : cq.cz;
        numx            = {mx[32:0], 30'd0} + 63'(len[31:1]);
        numy            = {my[32:0], 30'd0} + 63'(len[31:1]);
        numz            = {mz[32:0], 30'd0} + 63'(len[31:1]);
        sgn_in.neg_x    = cq.cx[32];
        sgn_in.neg_y    = cq.cy[32];
        sgn_in.neg_z    = cq.cz[32];
        sgn_in.len_zero = (len == 32'd0);
    end

    tnfg_udiv u_div_x (.aclk(aclk), .en(en), .num_i(numx), .den_i(len), .quo_o(qx));
    tnfg_udiv u_div_y (.aclk(aclk), .en(en), .num_i(numy), .den_i(len), .quo_o(qy));
    tnfg_udiv u_div_z (.aclk(aclk), .en(en), .num_i(numz), .den_i(len), .quo_o(qz));

    always_ff @(posedge aclk) begin
        if (en) begin
            sgn_pipe_reg[0] <= sgn_in;
            for (int i = 1; i < DIV_STEPS; i++) sgn_pipe_reg[i] <= sgn_pipe_reg[i-1];
        end
    end

    // sign, outward test, output
    side_t              sd;
    csign_t             sg;
    logic signed [31:0] n1x_reg;
    logic signed [31:0] n1y_reg;
    logic signed [31:0] n1z_reg;
    logic               ok1_reg;
    logic signed [31:0] p1x_reg;
    logic signed [31:0] p1y_reg;
    logic signed [31:0] p1z_reg;
    logic signed [63:0] prx_reg;
    logic signed [63:0] pry_reg;
    logic signed [63:0] prz_reg;
    logic signed [31:0] n2x_reg;
    logic signed [31:0] n2y_reg;
    logic signed [31:0] n2z_reg;
    logic               ok2_reg;
    logic signed [65:0] dot;
    logic               neg3_reg;
    logic signed [31:0] n3x_reg;
    logic signed [31:0] n3y_reg;
    logic signed [31:0] n3z_reg;
    logic               ok3_reg;
    logic               d1_vld_reg;
    logic               d2_vld_reg;
    logic               d3_vld_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    always_comb begin
        sd  = side_pipe_reg[SIDE_DEPTH-1];
        sg  = sgn_pipe_reg[DIV_STEPS-1];
        dot = 66'(prx_reg) + 66'(pry_reg) + 66'(prz_reg);
        if (!ok3_reg) begin
            m_tdata_next = '0;
        end else if (neg3_reg) begin
            m_tdata_next = {32'(-n3z_reg), 32'(-n3y_reg), 32'(-n3x_reg)};
        end else begin
            m_tdata_next = {n3z_reg, n3y_reg, n3x_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1x_reg  <= (sg.neg_x ^ sd.flip) ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            n1y_reg  <= (sg.neg_y ^ sd.flip) ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            n1z_reg  <= (sg.neg_z ^ sd.flip) ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
            ok1_reg  <= sd.ok && !sg.len_zero;
            p1x_reg  <= sd.px;
            p1y_reg  <= sd.py;
            p1z_reg  <= sd.pz;

            prx_reg  <= 64'(n1x_reg) * 64'(p1x_reg);
            pry_reg  <= 64'(n1y_reg) * 64'(p1y_reg);
            prz_reg  <= 64'(n1z_reg) * 64'(p1z_reg);
            n2x_reg  <= n1x_reg;
            n2y_reg  <= n1y_reg;
            n2z_reg  <= n1z_reg;
            ok2_reg  <= ok1_reg;

            neg3_reg <= dot[65];
            n3x_reg  <= n2x_reg;
            n3y_reg  <= n2y_reg;
            n3z_reg  <= n2z_reg;
            ok3_reg  <= ok2_reg;

            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= ok3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_vld_reg  <= 1'b0;
            d2_vld_reg  <= 1'b0;
            d3_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            d1_vld_reg  <= vld_pipe_reg[SIDE_DEPTH-1];
            d2_vld_reg  <= d1_vld_reg;
            d3_vld_reg  <= d2_vld_reg;
            m_valid_reg <= d3_vld_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

@@ rtl/core/tnfg_hstep.sv @@
// One Horner step h' = 1 - ((x2*h) >> 30) / d, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module tnfg_hstep (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [7:0]  div_i,
    input  wire logic [31:0] recip_i,
    input  wire logic [29:0] x2_i,
    input  wire logic [30:0] h_i,
    output logic      [30:0] h_o
);
    import tnfg_pkg::*;

    logic [60:0] xh;
    logic [29:0] p_reg;
    logic [61:0] pm;
    logic [29:0] q0_reg;
    logic [29:0] pb_reg;
    logic [37:0] qd;
    logic [29:0] rem;
    logic [29:0] q;
    logic [30:0] h_next;
    logic [30:0] h_reg;

    assign xh = 61'(x2_i) * 61'(h_i);
    assign pm = 62'(p_reg) * 62'(recip_i);

    // reciprocal estimate is low by at most one
    always_comb begin
        qd     = 38'(q0_reg) * 38'(div_i);
        rem    = pb_reg - qd[29:0];
        q      = (rem >= 30'(div_i)) ? q0_reg + 30'd1 : q0_reg;
        h_next = Q30_ONE - 31'(q);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg  <= xh[59:30];
            q0_reg <= pm[61:32];
            pb_reg <= p_reg;
            h_reg  <= h_next;
        end
    end

    assign h_o = h_reg;

endmodule

`default_nettype wire

@@ rtl/core/tnfg_sincos.sv @@
// Pipelined sine and cosine of an angle in degrees, Q30 results.
`timescale 1ns / 1ps
`default_nettype none

module tnfg_sincos (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [tnfg_pkg::LON_W-1:0] ang_i,
    output logic signed [31:0]                     sin_o,
    output logic signed [31:0]                     cos_o
);
    import tnfg_pkg::*;

    localparam int X_DEPTH  = HSTEP_LAT * SIN_STEPS + 1;
    localparam int S_DEPTH  = HSTEP_LAT * (COS_STEPS - SIN_STEPS) - 1;
    localparam int QS_DEPTH = SC_PRE + HSTEP_LAT * COS_STEPS;
    localparam int X2_DEPTH = HSTEP_LAT * (COS_STEPS - 1);

    // angle reduction
    logic [31:0] wrap_sum;
    logic [30:0] a_c;
    logic [30:0] r_c;
    logic [1:0]  quad_c;
    logic        swap_c;
    logic [27:0] t_c;

    always_comb begin
        wrap_sum = {ang_i[LON_W-1], ang_i} + {1'b0, DEG_FULL};
        a_c      = ang_i[LON_W-1] ? wrap_sum[30:0] : $unsigned(ang_i);
        priority if (a_c >= DEG_THREE_QUART) begin
            quad_c = 2'd3;
            r_c    = a_c - DEG_THREE_QUART;
        end else if (a_c >= DEG_HALF) begin
            quad_c = 2'd2;
            r_c    = a_c - DEG_HALF;
        end else if (a_c >= DEG_QUARTER) begin
            quad_c = 2'd1;
            r_c    = a_c - DEG_QUARTER;
        end else begin
            quad_c = 2'd0;
            r_c    = a_c;
        end
        swap_c = r_c > {3'b000, DEG_EIGHTH};
        t_c    = swap_c ? 28'(DEG_QUARTER - r_c) : r_c[27:0];
    end

    logic [27:0] t_reg;
    logic [60:0] prod_reg;
    logic [60:0] xsum;
    logic [29:0] x_reg;
    logic [59:0] xx_reg;
    logic [29:0] x2;
    logic [2:0]  qs_pipe_reg [QS_DEPTH];
    logic [29:0] x_pipe_reg  [X_DEPTH];
    logic [29:0] x2_pipe_reg [X2_DEPTH];

    assign xsum = prod_reg + (61'd1 << 29);
    assign x2   = xx_reg[59:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= t_c;
            prod_reg <= 61'(t_reg) * 61'(RAD_PER_DEG_Q38);
            x_reg    <= xsum[59:30];
            xx_reg   <= 60'(x_reg) * 60'(x_reg);
            qs_pipe_reg[0] <= {swap_c, quad_c};
            x_pipe_reg[0]  <= x_reg;
            x2_pipe_reg[0] <= x2;
            for (int i = 1; i < QS_DEPTH; i++) qs_pipe_reg[i] <= qs_pipe_reg[i-1];
            for (int i = 1; i < X_DEPTH; i++)  x_pipe_reg[i]  <= x_pipe_reg[i-1];
            for (int i = 1; i < X2_DEPTH; i++) x2_pipe_reg[i] <= x2_pipe_reg[i-1];
        end
    end

    // Horner chains share the delayed x2 taps
    logic [30:0] sh [SIN_STEPS+1];
    logic [30:0] ch [COS_STEPS+1];
    assign sh[0] = Q30_ONE;
    assign ch[0] = Q30_ONE;

    for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
        logic [29:0] x2_tap;
        if (i == 0) begin : g_first
            assign x2_tap = x2;
        end else begin : g_rest
            assign x2_tap = x2_pipe_reg[HSTEP_LAT*i-1];
        end
        tnfg_hstep u_cstep (
            .aclk    (aclk),
            .en      (en),
            .div_i   (COS_DIV[i]),
            .recip_i (COS_RECIP[i]),
            .x2_i    (x2_tap),
            .h_i     (ch[i]),
            .h_o     (ch[i+1])
        );
        if (i < SIN_STEPS) begin : g_sin
            tnfg_hstep u_sstep (
                .aclk    (aclk),
                .en      (en),
                .div_i   (SIN_DIV[i]),
                .recip_i (SIN_RECIP[i]),
                .x2_i    (x2_tap),
                .h_i     (sh[i]),
                .h_o     (sh[i+1])
            );
        end
    end

    logic [60:0] sprod;
    logic [30:0] s_pipe_reg [S_DEPTH+1];
    assign sprod = 61'(x_pipe_reg[X_DEPTH-1]) * 61'(sh[SIN_STEPS]);

    always_ff @(posedge aclk) begin
        if (en) begin
            s_pipe_reg[0] <= sprod[60:30];
            for (int i = 1; i <= S_DEPTH; i++) s_pipe_reg[i] <= s_pipe_reg[i-1];
        end
    end

    // octant and quadrant unfolding
    logic signed [31:0] s_oct;
    logic signed [31:0] c_oct;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic [2:0]         qs;

    always_comb begin
        qs    = qs_pipe_reg[QS_DEPTH-1];
        s_oct = qs[2] ? $signed({1'b0, ch[COS_STEPS]}) : $signed({1'b0, s_pipe_reg[S_DEPTH]});
        c_oct = qs[2] ? $signed({1'b0, s_pipe_reg[S_DEPTH]}) : $signed({1'b0, ch[COS_STEPS]});
        unique case (qs[1:0])
            2'd0: begin sin_next = s_oct;  cos_next = c_oct;  end
            2'd1: begin sin_next = c_oct;  cos_next = -s_oct; end
            2'd2: begin sin_next = -s_oct; cos_next = -c_oct; end
            default: begin sin_next = -c_oct; cos_next = s_oct; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

`default_nettype wire

@@ rtl/core/tnfg_isqrt.sv @@
// Pipelined integer square root of a 64-bit value, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tnfg_isqrt (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] rad_i,
    output logic      [31:0] root_o
);
    import tnfg_pkg::*;

    logic [63:0] n_pipe_reg   [SQRT_STEPS-1];
    logic [63:0] res_pipe_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*j);
        logic [63:0] n_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic        take;

        if (j == 0) begin : g_first
            assign n_in   = rad_i;
            assign res_in = 64'd0;
        end else begin : g_rest
            assign n_in   = n_pipe_reg[j-1];
            assign res_in = res_pipe_reg[j-1];
        end

        assign trial = res_in + BIT;
        assign take  = n_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                res_pipe_reg[j] <= take ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end

        if (j < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    n_pipe_reg[j] <= take ? n_in - trial : n_in;
                end
            end
        end
    end

    assign root_o = res_pipe_reg[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

@@ rtl/core/tnfg_udiv.sv @@
// Pipelined restoring divider: 63-bit numerator by 32-bit divisor, 31-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module tnfg_udiv (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [62:0] num_i,
    input  wire logic [31:0] den_i,
    output logic      [30:0] quo_o
);
    import tnfg_pkg::*;

    logic [31:0] rem_pipe_reg [DIV_STEPS-1];
    logic [31:0] den_pipe_reg [DIV_STEPS-1];
    logic [30:0] num_pipe_reg [DIV_STEPS-1];
    logic [30:0] quo_pipe_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic [31:0] rem_in;
        logic [31:0] den_in;
        logic [30:0] num_in;
        logic [30:0] quo_in;
        logic [32:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            // quotient fits 31 bits, so the top half is already below the divisor
            assign rem_in = num_i[62:31];
            assign den_in = den_i;
            assign num_in = num_i[30:0];
            assign quo_in = 31'd0;
        end else begin : g_rest
            assign rem_in = rem_pipe_reg[k-1];
            assign den_in = den_pipe_reg[k-1];
            assign num_in = num_pipe_reg[k-1];
            assign quo_in = quo_pipe_reg[k-1];
        end

        assign trial = {rem_in, num_in[DIV_STEPS-1-k]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_pipe_reg[k] <= {quo_in[29:0], take};
            end
        end

        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_pipe_reg[k] <= take ? 32'(trial - {1'b0, den_in}) : trial[31:0];
                    den_pipe_reg[k] <= den_in;
                    num_pipe_reg[k] <= num_in;
                end
            end
        end
    end

    assign quo_o = quo_pipe_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for the terrain normal pipeline: directed vertices, then random ones.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import tnfg_pkg::*;

    localparam longint FULL_TURN  = 1509949440;
    localparam longint QUARTER    = 377487360;
    localparam longint EIGHTH     = 188743680;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned RAD_K   = 64'd4797524517;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 120;

    typedef struct packed {
        logic signed [LAT_W-1:0]  lat;
        logic signed [LON_W-1:0]  lon;
        logic signed [ELEV_W-1:0] en;
        logic signed [ELEV_W-1:0] es;
        logic signed [ELEV_W-1:0] ee;
        logic signed [ELEV_W-1:0] ew;
        logic [MASK_W-1:0]        mask;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } vertex_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    upd;
    } normal_t;

    typedef struct {
        bit      elev_on;
        bit      ngen_on;
        vertex_t v;
        bit      zero_known;   // result is all zero and upd low
    } step_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [0:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MASK_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    terrain_normal_from_gradients i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bit      elev_en, ngen_en;
    normal_t normals_due[$];
    int      n_in, n_out, n_upd, errs;
    int      stall_cnt;
    bit      held;
    step_t   steps[$];

    // ---------------- predictor ----------------
    function automatic longint unsigned horner(longint unsigned x2, bit cos_chain);
        longint unsigned h;
        int n;
        h = ONE_Q30;
        n = cos_chain ? COS_STEPS : SIN_STEPS;
        for (int i = 0; i < n; i++)
            h = ONE_Q30 - ((x2 * h) >> 30) / (cos_chain ? longint'(COS_DIV[i])
                                                        : longint'(SIN_DIV[i]));
        return h;
    endfunction

    function automatic void trig_q30(input longint ang, output longint sn,
                                     output longint cs);
        longint a, q, r, s0, c0, s, c;
        longint unsigned t, x, x2;
        bit sw;
        a = ((ang % FULL_TURN) + FULL_TURN) % FULL_TURN;
        q = a / QUARTER;
        r = a - q * QUARTER;
        sw = r > EIGHTH;
        t = sw ? QUARTER - r : r;
        x = (t * RAD_K + (64'd1 << 29)) >> 30;
        x2 = (x * x) >> 30;
        s0 = longint'((x * horner(x2, 1'b0)) >> 30);
        c0 = longint'(horner(x2, 1'b1));
        s = sw ? c0 : s0;
        c = sw ? s0 : c0;
        case (q)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic longint round_q60(longint v);
        longint unsigned m;
        longint r;
        m = v < 0 ? longint'(-v) : v;
        r = longint'((m + (64'd1 << 29)) >> 30);
        return v < 0 ? -r : r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint scale_unit(longint c, longint unsigned l);
        longint unsigned m;
        longint r;
        m = c < 0 ? longint'(-c) : c;
        r = longint'(((m << 30) + l / 2) / l);
        return c < 0 ? -r : r;
    endfunction

    function automatic normal_t vertex_normal(vertex_t v);
        normal_t o;
        longint dn, de, sl, cl, sn, cn, cl2, cx, cy, cz, nx, ny, nz;
        longint unsigned l;
        o = '0;
        dn = longint'(v.en) - longint'(v.es);
        de = longint'(v.ee) - longint'(v.ew);
        if (!elev_en || !ngen_en || v.mask != 5'h1f || dn == 0 || de == 0) return o;
        trig_q30(longint'(v.lat), sl, cl);
        trig_q30(longint'(v.lon), sn, cn);
        cl2 = (cl * cl) >>> 30;
        cx = round_q60(sn * cl2 - sl * cn);
        cy = cl;
        cz = round_q60(-(cn * cl2) - sl * sn);
        l = int_sqrt(longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz));
        if (l == 0) return o;
        nx = scale_unit(cx, l);
        ny = scale_unit(cy, l);
        nz = scale_unit(cz, l);
        if ((dn < 0) != (de < 0)) begin
            nx = -nx; ny = -ny; nz = -nz;
        end
        if (nx * longint'(v.px) + ny * longint'(v.py) + nz * longint'(v.pz) < 0) begin
            nx = -nx; ny = -ny; nz = -nz;
        end
        o.nx = nx[31:0];
        o.ny = ny[31:0];
        o.nz = nz[31:0];
        o.upd = 1'b1;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic vertex_t vtx(longint lat, longint lon, int n, int s, int e, int w,
                                    logic [4:0] mask, longint px, longint py, longint pz);
        vertex_t v;
        v.lat = lat[LAT_W-1:0];
        v.lon = lon[LON_W-1:0];
        v.en = n[23:0]; v.es = s[23:0]; v.ee = e[23:0]; v.ew = w[23:0];
        v.mask = mask;
        v.px = px[31:0]; v.py = py[31:0]; v.pz = pz[31:0];
        return v;
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.lat = LAT_W'($urandom());
        v.lon = LON_W'($urandom());
        v.en = ELEV_W'($urandom()); v.es = ELEV_W'($urandom());
        v.ee = ELEV_W'($urandom()); v.ew = ELEV_W'($urandom());
        v.px = $urandom(); v.py = $urandom(); v.pz = $urandom();
        v.mask = 5'h1f;
        if ($urandom_range(99) < 12) begin
            // noise: broken mask, flat pairs, zero position
            case ($urandom_range(3))
                0: v.mask = MASK_W'($urandom());
                1: v.es = v.en;
                2: v.ew = v.ee;
                default: begin v.px = '0; v.py = '0; v.pz = '0; end
            endcase
        end
        return v;
    endfunction

    task automatic write_cfg(bit e, bit n);
        s_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ELEV_EN;
        cfg_wdata <= e;
        @(posedge aclk);
        cfg_index <= CFG_NGEN_EN;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        elev_en = e;
        ngen_en = n;
    endtask

    task automatic send_vertex(vertex_t v, bit zero_known, bit gaps);
        normal_t want;
        if (gaps) begin
            while ($urandom_range(99) < 31) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata <= {3'b0, v.pz, v.py, v.px, v.ew, v.ee, v.es, v.en, v.lon, v.lat};
        s_tuser <= v.mask;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = zero_known ? normal_t'('0) : vertex_normal(v);
        normals_due.push_back(want);
        n_in++;
    endtask

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        normal_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
            n_out++;
            if (normals_due.size() == 0) begin
                $error("normal word with no vertex pending");
                errs++;
            end else begin
                want = normals_due.pop_front();
                if (got.upd) n_upd++;
                if (got.nx !== want.nx) begin
                    $error("normal_x exp %0d got %0d", want.nx, got.nx); errs++;
                end
                if (got.ny !== want.ny) begin
                    $error("normal_y exp %0d got %0d", want.ny, got.ny); errs++;
                end
                if (got.nz !== want.nz) begin
                    $error("normal_z exp %0d got %0d", want.nz, got.nz); errs++;
                end
                if (got.upd !== want.upd) begin
                    $error("normal_updated exp %0d got %0d", want.upd, got.upd); errs++;
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off, one clean stretch
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!held && n_out >= 300) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_tready <= (n_out >= 1000 && n_out < 1300) || $urandom_range(99) >= 31;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        // directed steps: enables, mask bits, flat pairs, extremes, quadrants
        steps.push_back('{0, 0, vtx(0, 0, 16, 0, 16, 0, 5'h1f, 1, 1, 1), 1});
        steps.push_back('{1, 0, vtx(0, 0, 16, 0, 16, 0, 5'h1f, 1, 1, 1), 1});
        steps.push_back('{0, 1, vtx(0, 0, 16, 0, 16, 0, 5'h1f, 1, 1, 1), 1});
        for (int b = 0; b < MASK_W; b++)
            steps.push_back('{1, 1, vtx(1000, 2000, 5, 1, 5, 1, 5'h1f ^ (5'h1 << b),
                                        1, 1, 1), 1});
        steps.push_back('{1, 1, vtx(0, 0, 7, 7, 9, 1, 5'h1f, 1, 1, 1), 1});
        steps.push_back('{1, 1, vtx(0, 0, 7, 1, 9, 9, 5'h1f, 1, 1, 1), 1});
        steps.push_back('{1, 1, vtx(0, 0, 16, 0, 16, 0, 5'h1f, 0, 0, 0), 0});
        steps.push_back('{1, 1, vtx(377487360, 754974720, 8388607, -8388608, 8388607,
                                    -8388608, 5'h1f, 2147483647, 2147483647,
                                    2147483647), 0});
        steps.push_back('{1, 1, vtx(-377487360, -754974720, -8388608, 8388607, 8388607,
                                    -8388608, 5'h1f, -2147483648, -2147483648,
                                    -2147483648), 0});
        steps.push_back('{1, 1, vtx(188743680, 377487360, 1, 0, -1, 0, 5'h1f,
                                    -1, 5, -7), 0});
        steps.push_back('{1, 1, vtx(-536870912, 1073741823, 3, 2, 3, 2, 5'h1f,
                                    100, -100, 100), 0});
        steps.push_back('{1, 1, vtx(536870911, -1073741824, -3, 2, -3, 2, 5'h1f,
                                    -5, 0, 9), 0});
        steps.push_back('{1, 1, vtx(188743681, 1132462080, 1, -1, 1, -1, 5'h1f,
                                    0, 1 << 29, 0), 0});
        steps.push_back('{1, 1, vtx(-1, 1, 2, 1, 1, 2, 5'h1f, 3, 3, -3), 0});

        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steps[i]) begin
            if (steps[i].elev_on != elev_en || steps[i].ngen_on != ngen_en)
                write_cfg(steps[i].elev_on, steps[i].ngen_on);
            send_vertex(steps[i].v, steps[i].zero_known, 1'b1);
        end

        for (int i = 0; i < 2000; i++) begin
            if (i == 1700) write_cfg(1'b0, 1'b1);
            if (i == 1850) write_cfg(1'b1, 1'b1);
            send_vertex(rand_vertex(), 1'b0, !(i >= 800 && i < 1100));
        end
        s_tvalid <= 1'b0;

        while (normals_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("%0d vertices sent, %0d normals checked, %0d of them updated",
                 n_in, n_out, n_upd);
        $display("covered enable settings, masks, flat gradients, angle extremes, stalls");
        if (errs == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
